// ----- design/pes_pkg.sv -----
// Package for the periodic event scheduler: action/status codes and
// controller/datapath command and status structs. No dependencies.
package pes_pkg;

    localparam int ENTRIES_DEF   = 64;
    localparam int TIME_BITS_DEF = 48;
    localparam int ID_W          = 32;
    localparam int PER_W         = 32;
    localparam int ACT_W         = 2;
    localparam int STAT_W        = 3;

    localparam logic [ACT_W-1:0] ACT_REGISTER = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SERVE    = 2'd1;

    localparam logic [STAT_W-1:0] ST_REGISTERED = 3'd0;
    localparam logic [STAT_W-1:0] ST_SERVED     = 3'd1;
    localparam logic [STAT_W-1:0] ST_CLEARED    = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL       = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic load_req;    // capture request fields
        logic wr_entry;    // write new entry at count
        logic clr_count;   // empty the table
        logic scan_start;  // reset scan pointer, issue read of slot 0
        logic scan_step;   // compare read data, advance pointer
        logic rd_best;     // issue read of best slot
        logic upd_best;    // write advanced due time of best slot
    } pes_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_clear;
        logic is_register;
        logic full;
        logic empty;
        logic scan_done;
    } pes_stat_t;

endpackage

// ----- design/pes_datapath.sv -----
// Datapath of the periodic event scheduler: entry memory, scan pointer,
// best-candidate registers and the saturating due-time adder. Uses pes_pkg.
module pes_datapath #(
    parameter int ENTRIES   = pes_pkg::ENTRIES_DEF,
    parameter int TIME_BITS = pes_pkg::TIME_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pes_pkg::pes_cmd_t         cmd,
    output pes_pkg::pes_stat_t        stat,
    input  logic [pes_pkg::ACT_W-1:0] action,
    input  logic [pes_pkg::ID_W-1:0]  client_id,
    input  logic [pes_pkg::PER_W-1:0] period,
    output logic [pes_pkg::ID_W-1:0]  best_id
);
    import pes_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int ENT_W = ID_W + PER_W + TIME_BITS;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic [ENT_W-1:0]     mem [ENTRIES];
    logic [ENT_W-1:0]     rd_data_reg;
    logic [ACT_W-1:0]     act_reg;
    logic [ID_W-1:0]      id_reg;
    logic [PER_W-1:0]     per_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;   // slot whose data is in rd_data_reg
    logic [IDX_W-1:0]     best_idx_reg;
    logic [ID_W-1:0]      best_id_reg;
    logic [TIME_BITS-1:0] best_due_reg;
    logic                 best_vld_reg;

    logic [ID_W-1:0]      rd_id;
    logic [PER_W-1:0]     rd_per;
    logic [TIME_BITS-1:0] rd_due;
    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] due_adv;
    logic                 take;
    logic [CNT_W-1:0]     rd_ptr;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;

    assign rd_id  = rd_data_reg[ENT_W-1 -: ID_W];
    assign rd_per = rd_data_reg[TIME_BITS +: PER_W];
    assign rd_due = rd_data_reg[TIME_BITS-1:0];

    // Strictly earlier wins; equal due times go to the lower client id
    assign take = !best_vld_reg || (rd_due < best_due_reg) ||
                  ((rd_due == best_due_reg) && (rd_id < best_id_reg));

    // Saturating advance
    assign sum     = {1'b0, rd_due} + {{(TIME_BITS+1-PER_W){1'b0}}, rd_per};
    assign due_adv = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];

    assign stat.is_clear    = act_reg[1];
    assign stat.is_register = (act_reg == ACT_REGISTER);
    assign stat.full        = (count_reg >= CNT_W'(ENTRIES));
    assign stat.empty       = (count_reg == '0);
    assign stat.scan_done   = (ptr_reg + CNT_W'(1) >= count_reg);
    assign best_id          = best_id_reg;

    // Read address: next slot while scanning, else best slot
    always_comb
    begin
        rd_ptr  = cmd.scan_start ? '0 : ptr_reg + CNT_W'(1);
        rd_en   = cmd.scan_start || cmd.scan_step || cmd.rd_best;
        rd_addr = cmd.rd_best ? best_idx_reg : rd_ptr[IDX_W-1:0];
    end

    // Entry memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_entry)
        begin
            mem[count_reg[IDX_W-1:0]] <= {id_reg, per_reg,
                {{(TIME_BITS-PER_W){1'b0}}, per_reg}};
        end
        else if (cmd.upd_best)
        begin
            mem[best_idx_reg] <= {rd_id, rd_per, due_adv};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Request capture and best-candidate payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            act_reg <= action;
            id_reg  <= client_id;
            per_reg <= period;
        end
        if (cmd.scan_step && take)
        begin
            best_idx_reg <= ptr_reg[IDX_W-1:0];
            best_id_reg  <= rd_id;
            best_due_reg <= rd_due;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clr_count)
            count_next = '0;
        else if (cmd.wr_entry)
            count_next = count_reg + CNT_W'(1);
        ptr_next = ptr_reg;
        if (cmd.scan_start)
            ptr_next = '0;
        else if (cmd.scan_step)
            ptr_next = ptr_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ptr_reg      <= '0;
            best_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            if (cmd.scan_start)
                best_vld_reg <= 1'b0;
            else if (cmd.scan_step)
                best_vld_reg <= 1'b1;
        end
    end

endmodule

// ----- design/pes_ctrl.sv -----
// Controller of the periodic event scheduler: request sequencing and the
// output register. Uses pes_pkg.
module pes_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  logic                       out_ready,
    output pes_pkg::pes_cmd_t          cmd,
    input  pes_pkg::pes_stat_t         stat,
    input  logic [pes_pkg::ID_W-1:0]   best_id,
    output logic [pes_pkg::STAT_W-1:0] status,
    output logic [pes_pkg::ID_W-1:0]   served_id
);
    import pes_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_READ   = 5'b01000,
        S_UPDATE = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic               ovld_reg, ovld_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [ID_W-1:0]    sid_reg, sid_next;
    logic               done;

    // Result may be loaded once the output register is free or draining
    assign done      = !ovld_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovld_reg;
    assign status    = status_reg;
    assign served_id = sid_reg;

    always_comb
    begin
        state_next  = state_reg;
        ovld_next   = ovld_reg && !out_ready;
        status_next = status_reg;
        sid_next    = sid_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_clear || stat.is_register || stat.empty)
                begin
                    if (done)
                    begin
                        ovld_next = 1'b1;
                        sid_next  = '0;
                        if (stat.is_clear)
                        begin
                            cmd.clr_count = 1'b1;
                            status_next   = ST_CLEARED;
                        end
                        else if (stat.is_register)
                        begin
                            cmd.wr_entry = !stat.full;
                            status_next  = stat.full ? ST_FULL : ST_REGISTERED;
                        end
                        else
                        begin
                            status_next = ST_EMPTY;
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                    state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd_best = 1'b1;
                state_next  = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (done)
                begin
                    cmd.upd_best = 1'b1;
                    ovld_next    = 1'b1;
                    status_next  = ST_SERVED;
                    sid_next     = best_id;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        sid_reg    <= sid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovld_reg  <= ovld_next;
        end
    end

endmodule

// ----- design/periodic_event_scheduler.sv -----
// Periodic event scheduler. Register and clear requests, and a serve from
// an empty table, finish in the decode state; any other serve does a linear
// scan of the entry memory for the N clients in the table, one slot per
// cycle through its single read port, then one read and one write of the
// chosen slot. The result sits in an output register, so the next request
// is taken while it waits; a request that finishes while that register is
// still full stalls until the result is drained.
// Uses pes_pkg, pes_ctrl and pes_datapath.
module periodic_event_scheduler #(
    parameter int ENTRIES   = pes_pkg::ENTRIES_DEF,
    parameter int TIME_BITS = pes_pkg::TIME_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pes_pkg::ACT_W-1:0]   action,
    input  logic [pes_pkg::ID_W-1:0]    client_id,
    input  logic [pes_pkg::PER_W-1:0]   period,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pes_pkg::STAT_W-1:0]  status,
    output logic [pes_pkg::ID_W-1:0]    served_id
);
    import pes_pkg::*;

    pes_cmd_t        cmd;
    pes_stat_t       stat;
    logic [ID_W-1:0] best_id;

    pes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat),
        .best_id   (best_id),
        .status    (status),
        .served_id (served_id)
    );

    pes_datapath #(
        .ENTRIES   (ENTRIES),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .action    (action),
        .client_id (client_id),
        .period    (period),
        .best_id   (best_id)
    );

endmodule

// ----- design/pes_checker.sv -----
// Port-level checks for the periodic event scheduler, bound to the top.
// Uses pes_pkg.
module pes_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [pes_pkg::STAT_W-1:0] status,
    input logic [pes_pkg::ID_W-1:0]   served_id
);
    import pes_pkg::*;

    // Result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(served_id))
        else $error("result changed while stalled");

    // Status code is legal
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_EMPTY)
        else $error("illegal status");

    // served_id is zero unless served
    a_sid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_SERVED |-> served_id == '0)
        else $error("served_id nonzero");

    // No two requests are accepted back to back
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted back to back");

endmodule

bind periodic_event_scheduler pes_checker u_pes_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .served_id (served_id)
);

// ----- test/periodic_event_scheduler_tb.sv -----
// Testbench for periodic_event_scheduler: random and directed requests, with a
// scoreboard that predicts the served client. Depends on pes_pkg and the RTL.
`timescale 1ns / 1ps

module periodic_event_scheduler_tb;
    import pes_pkg::*;

    localparam int N_ENTRIES = ENTRIES_DEF;
    localparam int TBITS     = TIME_BITS_DEF;
    localparam logic [TBITS-1:0] DUE_MAX = {TBITS{1'b1}};
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic [ID_W-1:0]  id;
        logic [PER_W-1:0] per;
    } sched_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] st;
        logic [ID_W-1:0]   sid;
    } sched_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [ACT_W-1:0] action = '0;
    logic [ID_W-1:0] client_id = '0;
    logic [PER_W-1:0] period = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0] served_id;

    sched_req_t pending_reqs[$];
    sched_rsp_t expected_rsps[$];
    int error_count = 0;
    bit no_idle = 1'b0;
    bit stim_done = 1'b0;
    bit in_acc = 1'b0;
    int in_gap = 0;
    int out_gap = 0;

    // predictor copy of the client table
    logic [ID_W-1:0]  tbl_id[N_ENTRIES];
    logic [PER_W-1:0] tbl_per[N_ENTRIES];
    logic [TBITS-1:0] tbl_due[N_ENTRIES];
    int tbl_count = 0;

    periodic_event_scheduler DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .client_id(client_id), .period(period),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .served_id(served_id)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // compute the response to one request and update the table
    function automatic sched_rsp_t schedule_next(sched_req_t r);
        sched_rsp_t rsp;
        int best;
        logic [TBITS:0] sum;
        rsp = '0;
        if (r.act[1]) begin
            tbl_count = 0;
            rsp.st = ST_CLEARED;
        end else if (r.act == ACT_REGISTER) begin
            if (tbl_count >= N_ENTRIES) rsp.st = ST_FULL;
            else begin
                tbl_id[tbl_count] = r.id;
                tbl_per[tbl_count] = r.per;
                tbl_due[tbl_count] = TBITS'(r.per);
                tbl_count++;
                rsp.st = ST_REGISTERED;
            end
        end else if (tbl_count == 0) begin
            rsp.st = ST_EMPTY;
        end else begin
            best = 0;
            for (int i = 1; i < tbl_count; i++)
                if (tbl_due[i] < tbl_due[best] ||
                    (tbl_due[i] == tbl_due[best] && tbl_id[i] < tbl_id[best]))
                    best = i;
            rsp.st = ST_SERVED;
            rsp.sid = tbl_id[best];
            sum = {1'b0, tbl_due[best]} + (TBITS+1)'(tbl_per[best]);
            tbl_due[best] = sum > {1'b0, DUE_MAX} ? DUE_MAX : sum[TBITS-1:0];
        end
        return rsp;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic sched_req_t mk(logic [ACT_W-1:0] a, logic [ID_W-1:0] i,
                                     logic [PER_W-1:0] p);
        sched_req_t r;
        r.act = a; r.id = i; r.per = p;
        return r;
    endfunction

    // input monitor: predict each request at the edge that accepts it
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready) begin
            expected_rsps.push_back(schedule_next(mk(action, client_id, period)));
            in_acc = 1'b1;
        end
    end

    // driver: inputs change on the falling edge
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (in_acc) begin
                if (!no_idle && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 7);
            end
            if (!in_valid || in_acc) begin
                in_acc = 1'b0;
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    sched_req_t r;
                    r = pending_reqs.pop_front();
                    action <= r.act;
                    client_id <= r.id;
                    period <= r.per;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            // receiver stalls in bursts
            if (out_gap > 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                out_gap = $urandom_range(0, 6);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // monitor: sample on the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("response with no request pending");
            end else begin
                sched_rsp_t e;
                e = expected_rsps.pop_front();
                if (status !== e.st)
                    report_mismatch($sformatf("status %0d, want %0d", status, e.st));
                if (served_id !== e.sid)
                    report_mismatch($sformatf("served_id %h, want %h", served_id, e.sid));
            end
        end
    end

    // stimulus
    initial
    begin
        int kind;
        logic [ID_W-1:0] rid;
        logic [PER_W-1:0] rper;
        // directed: empty serve, extremes, ties, zero period, spare code
        pending_reqs.push_back(mk(ACT_SERVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(mk(ACT_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(mk(ACT_REGISTER, 32'h0, 32'h0));
        pending_reqs.push_back(mk(ACT_REGISTER, 32'h5, 32'h10));
        pending_reqs.push_back(mk(ACT_REGISTER, 32'h3, 32'h10));
        pending_reqs.push_back(mk(ACT_REGISTER, 32'h3, 32'h10));
        for (int i = 0; i < 6; i++) pending_reqs.push_back(mk(ACT_SERVE, '1, '1));
        pending_reqs.push_back(mk(ACT_SPARE, 32'hA5A5_A5A5, 32'h5A5A_5A5A));
        pending_reqs.push_back(mk(ACT_SERVE, '0, '0));
        pending_reqs.push_back(mk(ACT_REGISTER, 32'h7, 32'hFFFF_FFFF));
        for (int i = 0; i < 4; i++) pending_reqs.push_back(mk(ACT_SERVE, '0, '0));
        pending_reqs.push_back(mk(ACT_CLEAR, '0, '0));
        // fill to full, then overflow by one, then serve a few
        for (int i = 0; i < N_ENTRIES + 1; i++)
            pending_reqs.push_back(mk(ACT_REGISTER, $urandom, $urandom_range(0, 40)));
        for (int i = 0; i < 10; i++) pending_reqs.push_back(mk(ACT_SERVE, $urandom, $urandom));
        pending_reqs.push_back(mk(ACT_CLEAR, $urandom, $urandom));

        // random: mostly small tables, small periods and ids for ties
        for (int n = 0; n < 1855; n++) begin
            kind = $urandom_range(0, 99);
            rid = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
            case ($urandom_range(0, 5))
                0: rper = $urandom;
                1: rper = '0;
                2: rper = '1;
                default: rper = $urandom_range(1, 50);
            endcase
            if (kind < 40) pending_reqs.push_back(mk(ACT_REGISTER, rid, rper));
            else if (kind < 95) pending_reqs.push_back(mk(ACT_SERVE, $urandom, $urandom));
            else pending_reqs.push_back(mk($urandom_range(0, 1) ? ACT_CLEAR : ACT_SPARE,
                                           $urandom, $urandom));
        end

        repeat (12) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        wait (pending_reqs.size() < 200);
        no_idle = 1'b1;
        wait (pending_reqs.size() == 0 && !in_valid);
        wait (expected_rsps.size() == 0);
        repeat (N_ENTRIES + 20) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
